[sv/b64e_pkg.sv]
// b64e_pkg: shared types, constants and the alphabet lookup for the base64 stream encoder
// no dependencies; imported by every module of the block

package b64e_pkg;

    localparam int GroupWidth = 24;
    localparam logic [7:0] PadChar = 8'h3D;

    typedef enum logic
    {
        ACT_DATA = 1'b0,
        ACT_END  = 1'b1
    } action_t;

    // one complete or flushed group handed from front to back
    typedef struct packed
    {
        logic [GroupWidth-1:0] group;
        logic [1:0]            pad_cnt;
        logic                  done;
    } group_entry_t;

    // queue status seen by the front, the back and the top level
    typedef struct packed
    {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } queue_status_t;

    // six-bit value to alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] ch;
        begin
            if (idx < 6'd26)
            begin
                ch = 8'h41 + {2'b00, idx};
            end
            else if (idx < 6'd52)
            begin
                ch = 8'h61 + {2'b00, idx - 6'd26};
            end
            else if (idx < 6'd62)
            begin
                ch = 8'h30 + {2'b00, idx - 6'd52};
            end
            else if (idx == 6'd62)
            begin
                ch = 8'h2B;
            end
            else
            begin
                ch = 8'h2F;
            end
            return ch;
        end
    endfunction

endpackage

[sv/base64_stream_encoder.sv]
// base64_stream_encoder: top level of the streaming base64 encoder
// depends on b64e_pkg, b64e_front, b64e_queue and b64e_back
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per message byte with
//   action = data, then one word with action = end to close the message.
//   Output channel (out_valid/out_ready) carries one character per word.
//   Every third data byte yields four characters; the end word yields four
//   characters with '=' padding if one or two bytes are pending, else none.
//   run_last marks the fourth character of each run, message_done marks
//   characters that come from the end-of-message flush.
// Timing:
//   with the generator idle, a word completing a group is written into the
//   group queue and then into the output register, where out_valid rises; the
//   other three characters follow one per cycle while out_ready is high.
//   A two-entry group queue sits between the byte gatherer and the character
//   generator, so bytes keep being taken while the receiver stalls until the
//   queue is full; in_ready then drops.
// Reset:
//   rst_n clears the pending byte count, the queue pointers and count, the slot and out_valid.

module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       message_done
);

    queue_status_t q_status;
    group_entry_t  push_entry;
    group_entry_t  head;
    logic          push;
    logic          pop;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .data_byte  (data_byte),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    b64e_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .run_last     (run_last),
        .message_done (message_done)
    );

    // queue never overflows nor underflows
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.count != 2'd3))
        else $error("group queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop |-> !q_status.empty))
        else $error("pop from empty group queue");

    // pad characters only come from a flush
    assert property (@(posedge clk) disable iff (!rst_n)
        ((out_valid && (out_char == PadChar)) |-> message_done))
        else $error("pad character outside a flush");

    // a pad is followed by another pad or ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        ((out_valid && out_ready && (out_char == PadChar) && !run_last) |=>
            (!out_valid || (out_char == PadChar))))
        else $error("data character after pad in one run");

endmodule

[sv/b64e_front.sv]
// b64e_front: accepts input words, gathers pending bytes and classifies groups
// depends on b64e_pkg; pushes complete or flushed groups into b64e_queue

module b64e_front
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          action,
    input  logic [7:0]    data_byte,
    input  queue_status_t q_status,
    output logic          push,
    output group_entry_t  push_entry
);

    logic [15:0] pending_bytes_reg;
    logic [15:0] pending_bytes_next;
    logic [1:0]  pending_count_reg;
    logic [1:0]  pending_count_next;
    logic        accept;

    // room in the queue for a possible group
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // classify the word and build the next state
    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        push               = 1'b0;
        push_entry.group   = {pending_bytes_reg, data_byte};
        push_entry.pad_cnt = 2'd0;
        push_entry.done    = 1'b0;
        if (accept)
        begin
            if (action_t'(action) == ACT_DATA)
            begin
                case (pending_count_reg)
                    2'd1:
                    begin
                        pending_bytes_next = {pending_bytes_reg[15:8], data_byte};
                        pending_count_next = 2'd2;
                    end
                    2'd2:
                    begin
                        push               = 1'b1;
                        pending_count_next = 2'd0;
                    end
                    default:
                    begin
                        pending_bytes_next = {data_byte, 8'h00};
                        pending_count_next = 2'd1;
                    end
                endcase
            end
            else
            begin
                push_entry.done    = 1'b1;
                pending_count_next = 2'd0;
                case (pending_count_reg)
                    2'd1:
                    begin
                        push               = 1'b1;
                        push_entry.group   = {pending_bytes_reg[15:8], 16'h0000};
                        push_entry.pad_cnt = 2'd2;
                    end
                    2'd2:
                    begin
                        push               = 1'b1;
                        push_entry.group   = {pending_bytes_reg, 8'h00};
                        push_entry.pad_cnt = 2'd1;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    // pending count is control, pending bytes are payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_count_reg <= 2'd0;
        end
        else
        begin
            pending_count_reg <= pending_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_bytes_reg <= pending_bytes_next;
    end

endmodule

[sv/b64e_queue.sv]
// b64e_queue: two-entry queue of groups between front and back
// depends on b64e_pkg

module b64e_queue
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  group_entry_t  push_entry,
    input  logic          pop,
    output group_entry_t  head,
    output queue_status_t status
);

    group_entry_t mem_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign status.count = count_reg;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[sv/b64e_back.sv]
// b64e_back: turns each queued group into four characters, one per cycle while out_ready is high
// depends on b64e_pkg; pops entries from b64e_queue

module b64e_back
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  group_entry_t  head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          run_last,
    output logic          message_done
);

    logic [1:0] slot_reg;
    logic [1:0] slot_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       run_last_reg;
    logic       run_last_next;
    logic       done_reg;
    logic       done_next;
    logic       load;
    logic [5:0] sextet;
    logic [2:0] pad_sum;

    assign load = !q_status.empty && (!out_valid_reg || out_ready);
    assign pop  = load && (slot_reg == 2'd3);

    // pick the six-bit slice for the current slot, most significant first
    always_comb
    begin
        case (slot_reg)
            2'd0:    sextet = head.group[23:18];
            2'd1:    sextet = head.group[17:12];
            2'd2:    sextet = head.group[11:6];
            default: sextet = head.group[5:0];
        endcase
    end

    // slot falls into the padded tail when slot + pad_cnt reaches four
    assign pad_sum = {1'b0, slot_reg} + {1'b0, head.pad_cnt};

    // output register update
    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;
        done_next      = done_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = pad_sum[2] ? PadChar : b64_char(sextet);
            run_last_next  = (slot_reg == 2'd3);
            done_next      = head.done;
            slot_next      = slot_reg + 2'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        run_last_reg <= run_last_next;
        done_reg     <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign run_last     = run_last_reg;
    assign message_done = done_reg;

endmodule
